// File: hdl/fvn_pkg.sv
package fvn_pkg;

    localparam int DEF_MAX_OCTAVES = 16;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;
    localparam int Q_W             = 24;

    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;

    localparam logic [1:0] MODE_FBM   = 2'd0;
    localparam logic [1:0] MODE_TURB  = 2'd1;
    localparam logic [1:0] MODE_RIDGE = 2'd2;
    localparam logic [1:0] MODE_OFF   = 2'd3;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_OCTAVES = 2'd1;
    localparam logic [1:0] REG_LACUN   = 2'd2;
    localparam logic [1:0] REG_GAIN    = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  octaves;
        logic [15:0] lacunarity;
        logic [15:0] gain;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SX, ST_SY, ST_FX, ST_TX, ST_FY, ST_TY,
        ST_H0A, ST_H0B, ST_H1A, ST_H1B, ST_CA, ST_CB,
        ST_BL1, ST_BL2, ST_BL3, ST_N, ST_M1, ST_M2, ST_M3,
        ST_R, ST_DIV, ST_DONE
    } state_t;

    function automatic logic [31:0] mix_pre(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] mix_mid(input logic [31:0] v);
        return v ^ (v >> 15);
    endfunction

    function automatic logic [31:0] mix_fin(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// File: hdl/fvn_mul.sv
module fvn_mul
    import fvn_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: hdl/fvn_div.sv
module fvn_div
    import fvn_pkg::*;
#(
    parameter int NUM_W = 61,
    parameter int DEN_W = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int SH_W  = DEN_W + Q_W - 1;
    localparam int CW    = (NUM_W > SH_W) ? NUM_W : SH_W;
    localparam int CNT_W = $clog2(Q_W);

    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic             ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = CW'(num);
            dsh_next = CW'(den) << (Q_W - 1);
            cnt_next = CNT_W'(Q_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (ge)
                rem_next = rem_reg - dsh_reg;
            q_next   = {q_reg[Q_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: hdl/fvn_regs.sv
module fvn_regs
    import fvn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg, cfg_next;
    logic wr;

    assign wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:    cfg_next.mode       = pwdata[1:0];
                REG_OCTAVES: cfg_next.octaves    = pwdata[4:0];
                REG_LACUN:   cfg_next.lacunarity = pwdata[15:0];
                REG_GAIN:    cfg_next.gain       = pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:    prdata = DATA_W'(cfg_reg.mode);
            REG_OCTAVES: prdata = DATA_W'(cfg_reg.octaves);
            REG_LACUN:   prdata = DATA_W'(cfg_reg.lacunarity);
            REG_GAIN:    prdata = DATA_W'(cfg_reg.gain);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_FBM;
            cfg_reg.octaves    <= 5'd4;
            cfg_reg.lacunarity <= 16'd8192;
            cfg_reg.gain       <= 16'd16384;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/fractal_value_noise_2d_top.sv
// Fractal 2D value noise. Each word of (x_coord, y_coord), signed Q16.16,
// yields one noise_out word, unsigned Q2.22, saturated. A small sequencer
// drives one registered 33x33 signed multiplier through every product of an
// octave: coordinate scaling, two smoothstep curves, the integer hash mix of
// two cell columns and four corners, three interpolations and the per-mode
// update. A word is accepted in the idle state and its result handed off in
// the done state; turbulence and ridged mode also pass a finish state that
// folds in the last octave's term, and fbm mode runs the bit-serial
// normalizing divider (one quotient bit per cycle, 24 bits). The reset setting
// is fbm with four octaves. in_ready is high only between words; a finished
// word waits in the output register, so the next word can be taken while it is
// pending. Registers sit at byte offsets 0 (mode), 4 (octaves), 8 (lacunarity
// Q4.12), 12 (gain Q1.15); mode 3 answers zero at once.
module fractal_value_noise_2d_top
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [23:0]        noise_out
);

    localparam int IW     = $clog2(MAX_OCTAVES + 1);
    localparam int ASUM_W = 33 + $clog2(MAX_OCTAVES);
    localparam int SUM_W  = 57 + $clog2(MAX_OCTAVES);
    localparam int DEN_W  = ASUM_W + 2;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [31:0]       x_reg, x_next, y_reg, y_next;
    logic [31:0]       freq_reg, freq_next, amp_reg, amp_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [ASUM_W-1:0] asum_reg, asum_next;
    logic [IW-1:0]     oct_reg, oct_next, eoct_reg, eoct_next;
    logic [31:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic [16:0]       tx_reg, tx_next, ty_reg, ty_next;
    logic [31:0]       hx0_reg, hx0_next, hx1_reg, hx1_next;
    logic [23:0]       c_reg [4], c_next [4];
    logic [1:0]        crn_reg, crn_next;
    logic [23:0]       a_reg, a_next;
    logic [23:0]       res_reg, res_next;
    logic [23:0]       out_data_reg, out_data_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic               div_start, div_done;
    logic [Q_W-1:0]     div_q;

    // per-cycle helpers
    logic [31:0] p32, pf;
    logic [15:0] ix, ix1, iy, iy1, cj;
    logic [31:0] chash;
    logic [23:0] lerp, nval;
    logic [24:0] dev, ridge;
    logic [32:0] fdbl;
    logic [SUM_W-1:0] s2;
    logic        last_oct;

    fvn_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    fvn_mul u_mul (
        .clk (clk),
        .a   (op_a),
        .b   (op_b),
        .p   (prod)
    );

    fvn_div #(
        .NUM_W (SUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   ({asum_reg, 2'b00}),
        .done  (div_done),
        .quot  (div_q)
    );

    assign pready    = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign noise_out = out_data_reg;

    assign p32   = prod[31:0];
    assign pf    = mix_fin(p32);
    assign ix    = sx_reg[31:16];
    assign iy    = sy_reg[31:16];
    assign ix1   = ix + 16'd1;
    assign iy1   = iy + 16'd1;
    assign cj    = crn_reg[1] ? iy1 : iy;
    assign chash = (crn_reg[0] ? hx1_reg : hx0_reg) + sext16(cj);
    // a + ((b - a) * t) >>> 16, result always lands in [0, 2^24)
    assign lerp  = 24'(a_reg + 24'(prod[40:16]));
    assign nval  = lerp;
    assign dev   = ({nval, 1'b0} >= 25'h1000000) ? ({nval, 1'b0} - 25'h1000000)
                                                 : (25'h1000000 - {nval, 1'b0});
    assign ridge = 25'h1000000 - dev;
    assign fdbl  = {freq_reg, 1'b0};
    assign s2    = sum_reg >> 2;
    assign last_oct = (oct_reg + 1'b1) == eoct_reg;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        freq_next      = freq_reg;
        amp_next       = amp_reg;
        sum_next       = sum_reg;
        asum_next      = asum_reg;
        oct_next       = oct_reg;
        eoct_next      = eoct_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        hx0_next       = hx0_reg;
        hx1_next       = hx1_reg;
        c_next         = c_reg;
        crn_next       = crn_reg;
        a_next         = a_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_a           = '0;
        op_b           = '0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = x_coord;
                    y_next    = y_coord;
                    freq_next = 32'h0001_0000;
                    amp_next  = 32'd32768;
                    sum_next  = '0;
                    asum_next = '0;
                    oct_next  = '0;
                    if (cfg.octaves == 5'd0)
                        eoct_next = IW'(1);
                    else if (int'(cfg.octaves) > MAX_OCTAVES)
                        eoct_next = IW'(MAX_OCTAVES);
                    else
                        eoct_next = IW'(cfg.octaves);
                    if (cfg.mode == MODE_OFF)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SX;
                    end
                end
            end
            ST_SX:
            begin
                op_a       = {x_reg[31], x_reg};
                op_b       = {1'b0, freq_reg};
                state_next = ST_SY;
            end
            ST_SY:
            begin
                sx_next    = prod[47:16];
                op_a       = {y_reg[31], y_reg};
                op_b       = {1'b0, freq_reg};
                state_next = ST_FX;
            end
            ST_FX:
            begin
                sy_next    = prod[47:16];
                op_a       = {17'd0, sx_reg[15:0]};
                op_b       = {17'd0, sx_reg[15:0]};
                state_next = ST_TX;
            end
            ST_TX:
            begin
                op_a       = {1'b0, p32};
                op_b       = {15'd0, 18'd196608 - {1'b0, sx_reg[15:0], 1'b0}};
                state_next = ST_FY;
            end
            ST_FY:
            begin
                tx_next    = prod[48:32];
                op_a       = {17'd0, sy_reg[15:0]};
                op_b       = {17'd0, sy_reg[15:0]};
                state_next = ST_TY;
            end
            ST_TY:
            begin
                op_a       = {1'b0, p32};
                op_b       = {15'd0, 18'd196608 - {1'b0, sy_reg[15:0], 1'b0}};
                state_next = ST_H0A;
            end
            ST_H0A:
            begin
                ty_next    = prod[48:32];
                op_a       = {1'b0, mix_pre(sext16(ix))};
                op_b       = {1'b0, MIX_C1};
                state_next = ST_H0B;
            end
            ST_H0B:
            begin
                op_a       = {1'b0, mix_mid(p32)};
                op_b       = {1'b0, MIX_C2};
                state_next = ST_H1A;
            end
            ST_H1A:
            begin
                hx0_next   = pf;
                op_a       = {1'b0, mix_pre(sext16(ix1))};
                op_b       = {1'b0, MIX_C1};
                state_next = ST_H1B;
            end
            ST_H1B:
            begin
                op_a       = {1'b0, mix_mid(p32)};
                op_b       = {1'b0, MIX_C2};
                crn_next   = 2'd0;
                state_next = ST_CA;
            end
            ST_CA:
            begin
                // retire the hash that just came out, start the next corner
                if (crn_reg == 2'd0)
                    hx1_next = pf;
                else
                    c_next[crn_reg - 2'd1] = pf[23:0];
                op_a       = {1'b0, mix_pre(chash)};
                op_b       = {1'b0, MIX_C1};
                state_next = ST_CB;
            end
            ST_CB:
            begin
                op_a     = {1'b0, mix_mid(p32)};
                op_b     = {1'b0, MIX_C2};
                crn_next = crn_reg + 2'd1;
                if (crn_reg == 2'd3)
                    state_next = ST_BL1;
                else
                    state_next = ST_CA;
            end
            ST_BL1:
            begin
                c_next[3]  = pf[23:0];
                op_a       = 33'(signed'({1'b0, c_reg[1]} - {1'b0, c_reg[0]}));
                op_b       = {16'd0, tx_reg};
                state_next = ST_BL2;
            end
            ST_BL2:
            begin
                a_next     = 24'(c_reg[0] + 24'(prod[40:16]));
                op_a       = 33'(signed'({1'b0, c_reg[3]} - {1'b0, c_reg[2]}));
                op_b       = {16'd0, tx_reg};
                state_next = ST_BL3;
            end
            ST_BL3:
            begin
                op_a = 33'(signed'({1'b0, 24'(c_reg[2] + 24'(prod[40:16]))}
                                   - {1'b0, a_reg}));
                op_b       = {16'd0, ty_reg};
                state_next = ST_N;
            end
            ST_N:
            begin
                case (cfg.mode)
                    MODE_FBM:
                    begin
                        op_a       = {9'd0, nval};
                        op_b       = {1'b0, amp_reg};
                        state_next = ST_M1;
                    end
                    MODE_RIDGE:
                    begin
                        op_a       = {8'd0, ridge};
                        op_b       = {8'd0, ridge};
                        state_next = ST_R;
                    end
                    default:
                    begin
                        sum_next  = sum_reg + SUM_W'(dev >> oct_reg);
                        freq_next = fdbl[32] ? 32'hFFFF_FFFF : fdbl[31:0];
                        oct_next  = oct_reg + 1'b1;
                        // the last add lands next cycle; finish in ST_M3
                        if (last_oct)
                            state_next = ST_M3;
                        else
                            state_next = ST_SX;
                    end
                endcase
            end
            ST_R:
            begin
                sum_next   = sum_reg + SUM_W'(prod[48:24] >> oct_reg);
                freq_next  = fdbl[32] ? 32'hFFFF_FFFF : fdbl[31:0];
                oct_next   = oct_reg + 1'b1;
                // the last add lands next cycle; ST_M3 takes the finish path
                // with the updated sum
                if (last_oct)
                    state_next = ST_M3;
                else
                    state_next = ST_SX;
            end
            ST_M1:
            begin
                sum_next   = sum_reg + SUM_W'(prod[55:0]);
                asum_next  = asum_reg + ASUM_W'(amp_reg);
                op_a       = {1'b0, amp_reg};
                op_b       = {17'd0, cfg.gain};
                state_next = ST_M2;
            end
            ST_M2:
            begin
                amp_next   = prod[47] ? 32'hFFFF_FFFF : prod[46:15];
                op_a       = {1'b0, freq_reg};
                op_b       = {17'd0, cfg.lacunarity};
                state_next = ST_M3;
            end
            ST_M3:
            begin
                if (cfg.mode == MODE_FBM)
                begin
                    freq_next = (|prod[47:44]) ? 32'hFFFF_FFFF : prod[43:12];
                    oct_next  = oct_reg + 1'b1;
                    if (last_oct)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_SX;
                    end
                end
                else
                begin
                    // turbulence and ridged finish: sum now holds every octave
                    res_next   = (|s2[SUM_W-1:24]) ? 24'hFF_FFFF : s2[23:0];
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_q;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            oct_reg       <= '0;
            eoct_reg      <= IW'(1);
            crn_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            oct_reg       <= oct_next;
            eoct_reg      <= eoct_next;
            crn_reg       <= crn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        freq_reg     <= freq_next;
        amp_reg      <= amp_next;
        sum_reg      <= sum_next;
        asum_reg     <= asum_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        hx0_reg      <= hx0_next;
        hx1_reg      <= hx1_next;
        c_reg        <= c_next;
        a_reg        <= a_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // divider answers only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide wait");

    // octave index stays below the octave count while an octave is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SX || state_reg == ST_N) |-> oct_reg < eoct_reg)
        else $error("octave index out of range");

    // the fourth corner hands over to interpolation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CB && crn_reg == 2'd3) |=> state_reg == ST_BL1)
        else $error("corner sequence overran");

    // a result is loaded only when the output register is free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> state_reg == ST_DONE)
        else $error("result overwrote a pending word");

endmodule

// File: verif/fractal_value_noise_2d_top_tb.sv
`timescale 1ns / 1ps

// Testbench for fractal_value_noise_2d_top.
// Drive (x_coord, y_coord) words, predict each noise_out word in the bench and
// compare in order. Run a directed table first, then random phases that each
// rewrite every register, including out-of-range values that must be masked or
// clamped.
module fractal_value_noise_2d_top_tb;
    import fvn_pkg::*;

    localparam int  LIMIT_CYCLES = 2_000_000;
    localparam int  HOLD_CYCLES  = 600;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  NUM_PHASES   = 12;
    localparam int  NUM_DIR      = 15;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic               out_valid;
    logic               out_ready;
    logic [23:0]        noise_out;

    fractal_value_noise_2d_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .noise_out (noise_out)
    );

    // Bench copy of the register file, updated on every write.
    cfg_t cfg_shadow;

    // Expected noise words, oldest first.
    logic [23:0] noise_q[$];

    int  err_cnt;
    int  words_checked;
    int  words_per_mode[4];
    int  cycle_cnt;
    bit  no_idle;
    int  hold_req;
    int  hold_seen;
    int  hold_left;

    // Typed expectation for the word being offered, if any.
    bit          word_typed;
    logic [23:0] word_typed_val;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        bit          mode_off;
        bit          typed;
        logic [23:0] val;
    } dir_row_t;

    typedef struct {
        logic [1:0]  mode;
        logic [4:0]  octaves;
        logic [15:0] lacunarity;
        logic [15:0] gain;
        int          words;
    } phase_t;

    //------------------------------------------------------------------
    // Noise predictor
    //------------------------------------------------------------------
    function automatic logic [31:0] hash_mix(input logic [31:0] v);
        logic [31:0] w;
        w = v ^ (v >> 16);
        w = w * MIX_C1;
        w = w ^ (w >> 15);
        w = w * MIX_C2;
        w = w ^ (w >> 16);
        return w;
    endfunction

    // Q16.16 coordinate times Q16.16 frequency, floor, low 32 bits kept.
    function automatic logic [31:0] scale_pos(input logic [31:0] c, input logic [31:0] freq);
        logic [63:0] prod;
        prod = {{32{c[31]}}, c} * {32'd0, freq};
        return prod[47:16];
    endfunction

    function automatic logic [15:0] ease_curve(input logic [15:0] f);
        logic [63:0] f2;
        logic [63:0] g;
        logic [63:0] p;
        f2 = {48'd0, f} * {48'd0, f};
        g  = 64'd196608 - 2 * {48'd0, f};
        p  = f2 * g;
        return p[47:32];
    endfunction

    function automatic logic [31:0] mix_lin(input logic [31:0] a, input logic [31:0] b,
                                            input logic [15:0] t);
        logic [63:0] s;
        s = {32'd0, a} * (64'd65536 - t) + {32'd0, b} * t;
        return s[47:16];
    endfunction

    function automatic logic [31:0] cell_value(input logic [15:0] i, input logic [15:0] j);
        logic [31:0] h;
        h = hash_mix(hash_mix({{16{i[15]}}, i}) + {{16{j[15]}}, j});
        return {8'd0, h[23:0]};
    endfunction

    function automatic logic [31:0] octave_noise(input logic [31:0] sx, input logic [31:0] sy);
        logic [15:0] ix;
        logic [15:0] iy;
        logic [15:0] tx;
        logic [15:0] ty;
        logic [31:0] a;
        logic [31:0] b;
        ix = sx[31:16];
        iy = sy[31:16];
        tx = ease_curve(sx[15:0]);
        ty = ease_curve(sy[15:0]);
        a  = mix_lin(cell_value(ix, iy), cell_value(ix + 16'd1, iy), tx);
        b  = mix_lin(cell_value(ix, iy + 16'd1), cell_value(ix + 16'd1, iy + 16'd1), tx);
        return mix_lin(a, b, ty);
    endfunction

    function automatic logic [23:0] fractal_noise(input cfg_t c, input logic [31:0] x,
                                                  input logic [31:0] y);
        int          oct;
        logic [63:0] freq;
        logic [63:0] amp;
        logic [63:0] acc;
        logic [63:0] amp_acc;
        logic [63:0] res;
        logic [63:0] n;
        logic [63:0] dev;
        logic [63:0] r;
        logic [63:0] term;
        oct     = c.octaves;
        freq    = 64'h10000;
        amp     = 64'd32768;
        acc     = 0;
        amp_acc = 0;
        if (oct == 0)
            oct = 1;
        if (oct > DEF_MAX_OCTAVES)
            oct = DEF_MAX_OCTAVES;
        if (c.mode == MODE_OFF)
            return 24'd0;
        for (int i = 0; i < oct; i++)
        begin
            n   = {32'd0, octave_noise(scale_pos(x, freq[31:0]), scale_pos(y, freq[31:0]))};
            dev = (2 * n >= 64'd16777216) ? 2 * n - 64'd16777216 : 64'd16777216 - 2 * n;
            if (c.mode == MODE_FBM)
            begin
                acc     += n * amp;
                amp_acc += amp;
                amp      = (amp * c.gain) >> 15;
                if (amp > 64'hFFFF_FFFF)
                    amp = 64'hFFFF_FFFF;
                freq = (freq * c.lacunarity) >> 12;
            end
            else
            begin
                if (c.mode == MODE_TURB)
                    term = dev;
                else
                begin
                    r    = 64'd16777216 - dev;
                    term = (r * r) >> 24;
                end
                acc += term >> i;
                freq = freq << 1;
            end
            if (freq > 64'hFFFF_FFFF)
                freq = 64'hFFFF_FFFF;
        end
        if (c.mode == MODE_FBM)
            res = acc / (amp_acc * 4);
        else
            res = acc >> 2;
        if (res > 64'hFF_FFFF)
            res = 64'hFF_FFFF;
        return res[23:0];
    endfunction

    //------------------------------------------------------------------
    // Clock, cycle limit
    //------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Stop a hung run; the limit is several times the slowest correct run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycle_cnt, noise_q.size());
            $display("[fractal_value_noise_2d_top] ERROR");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Scoreboard: predict on input accept, compare on output accept
    //------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (word_typed)
                    noise_q.push_back(word_typed_val);
                else
                    noise_q.push_back(fractal_noise(cfg_shadow, x_coord, y_coord));
            end
            if (out_valid && out_ready)
            begin
                if (noise_q.size() == 0)
                    report_mismatch($sformatf("noise_out %06h with nothing expected", noise_out));
                else
                begin
                    if (noise_out !== noise_q[0])
                        report_mismatch($sformatf("noise_out got %06h want %06h",
                                                  noise_out, noise_q[0]));
                    void'(noise_q.pop_front());
                    words_checked++;
                    words_per_mode[cfg_shadow.mode]++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Receiver: random stalls, plus long hold-offs on request
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_left > 0)
        begin
            // hold off so the block fills and stalls its input
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
        else
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
    end

    //------------------------------------------------------------------
    // Sender and register port
    //------------------------------------------------------------------
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the write lands at this edge; mirror it with the register masks
        case (idx)
            REG_MODE:    cfg_shadow.mode       = val[1:0];
            REG_OCTAVES: cfg_shadow.octaves    = val[4:0];
            REG_LACUN:   cfg_shadow.lacunarity = val[15:0];
            default:     cfg_shadow.gain       = val[15:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for every expected word, then let the pipeline settle.
    task automatic drain();
        while (noise_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offer one word and hold it until accepted, then maybe idle.
    task automatic send_word(input logic [31:0] x, input logic [31:0] y,
                             input bit typed, input logic [23:0] val);
        int gap;
        in_valid       <= 1'b1;
        x_coord        <= x;
        y_coord        <= y;
        word_typed     <= typed;
        word_typed_val <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (!no_idle && $urandom_range(99) < 17)
        begin
            gap = $urandom_range(8, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random point: mostly full range, some near the origin, a few at the edges.
    task automatic rand_point(output logic [31:0] x, output logic [31:0] y);
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            x = $urandom;
            y = $urandom;
        end
        else if (pick < 8)
        begin
            x = $urandom_range(32'h0008_0000) - 32'h0004_0000;
            y = $urandom_range(32'h0008_0000) - 32'h0004_0000;
        end
        else
        begin
            x = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3) : 32'h8000_0000 + $urandom_range(3);
            y = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom_range(3);
        end
    endtask

    dir_row_t dir_tab[NUM_DIR] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 24'd0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'd0},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 24'd0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 24'd0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 24'd0},
        '{32'h0000_8000, 32'hFFFF_8000, 1'b0, 1'b0, 24'd0},
        '{32'h0000_FFFF, 32'hFFFF_0000, 1'b0, 1'b0, 24'd0},
        '{32'h7FFF_0000, 32'h8000_FFFF, 1'b0, 1'b0, 24'd0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 24'd0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, 24'd0},
        '{32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b0, 24'd0},
        // unused mode answers zero whatever the point
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 24'd0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 24'd0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 24'd0},
        '{32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b1, 1'b1, 24'd0}
    };

    // Every phase rewrites all four registers; out-of-range values included.
    phase_t phase_tab[NUM_PHASES] = '{
        '{MODE_FBM,   5'd4,  16'd8192,  16'd16384, 100},
        '{MODE_TURB,  5'd3,  16'd0,     16'd0,     80},
        '{MODE_RIDGE, 5'd5,  16'd8192,  16'd16384, 80},
        '{MODE_FBM,   5'd1,  16'd0,     16'd0,     60},
        '{MODE_FBM,   5'd16, 16'd65535, 16'd32768, 25},
        '{MODE_TURB,  5'd16, 16'd1234,  16'd4321,  25},
        '{MODE_RIDGE, 5'd0,  16'd65535, 16'd65535, 60},
        '{MODE_FBM,   5'd31, 16'd4096,  16'd65535, 25},
        '{MODE_OFF,   5'd7,  16'd8192,  16'd16384, 40},
        '{MODE_FBM,   5'd2,  16'd0,     16'd0,     100},
        '{MODE_RIDGE, 5'd2,  16'd12288, 16'd24576, 100},
        '{MODE_TURB,  5'd6,  16'd8192,  16'd16384, 100}
    };

    initial
    begin
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] lac;
        logic [15:0] gn;
        bit          off_now;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        x_coord        = '0;
        y_coord        = '0;
        word_typed     = 1'b0;
        word_typed_val = '0;
        err_cnt        = 0;
        words_checked  = 0;
        words_per_mode = '{0, 0, 0, 0};
        cycle_cnt      = 0;
        no_idle        = 1'b0;
        hold_req       = 0;
        off_now        = 1'b0;
        cfg_shadow     = '{mode: MODE_FBM, octaves: 5'd4, lacunarity: 16'd8192,
                           gain: 16'd16384};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset setting, then with the unused mode.
        foreach (dir_tab[k])
        begin
            if (dir_tab[k].mode_off != off_now)
            begin
                in_valid <= 1'b0;
                drain();
                reg_write(REG_MODE, dir_tab[k].mode_off ? 32'(MODE_OFF) : 32'(MODE_FBM));
                off_now = dir_tab[k].mode_off;
            end
            send_word(dir_tab[k].x, dir_tab[k].y, dir_tab[k].typed, dir_tab[k].val);
        end

        // Random phases.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            in_valid <= 1'b0;
            drain();
            lac = phase_tab[p].lacunarity;
            gn  = phase_tab[p].gain;
            if (p == 9)
            begin
                lac = 16'($urandom);
                gn  = 16'($urandom);
            end
            // set junk in the upper bits to exercise the register masks
            reg_write(REG_MODE,    {8'($urandom_range(255)), 22'd0, phase_tab[p].mode});
            reg_write(REG_OCTAVES, {8'($urandom_range(255)), 19'd0, phase_tab[p].octaves});
            reg_write(REG_LACUN,   {16'($urandom_range(65535)), lac});
            reg_write(REG_GAIN,    {16'($urandom_range(65535)), gn});
            no_idle = (p == 2);
            for (int w = 0; w < phase_tab[p].words; w++)
            begin
                if (p == 0 && w == 30)
                    hold_req++;
                if (p == 1 && w == 40)
                begin
                    // pause the sender until every word is back
                    in_valid <= 1'b0;
                    while (noise_q.size() != 0)
                        @(posedge clk);
                end
                rand_point(px, py);
                send_word(px, py, 1'b0, 24'd0);
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (noise_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d noise words: fbm %0d, turbulence %0d, ridged %0d, unused mode %0d",
                 words_checked, words_per_mode[0], words_per_mode[1], words_per_mode[2],
                 words_per_mode[3]);
        $display("octaves 0..31, lacunarity and gain 0..65535, long output hold-off, %0d errors",
                 err_cnt);
        if (err_cnt == 0)
            $display("[fractal_value_noise_2d_top] OK");
        else
            $display("[fractal_value_noise_2d_top] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hdl/fvn_pkg.sv
hdl/fvn_mul.sv
hdl/fvn_div.sv
hdl/fvn_regs.sv
hdl/fractal_value_noise_2d_top.sv
verif/fractal_value_noise_2d_top_tb.sv
